// ----- rtl/imu_tilt_complementary_filter_macros.svh -----
// Assertion macros for the tilt filter blocks.
// Expects signals clk and arst_n in the scope of use.
`ifndef IMU_TILT_COMPLEMENTARY_FILTER_MACROS_SVH
`define IMU_TILT_COMPLEMENTARY_FILTER_MACROS_SVH

// same-cycle implication
`define ITCF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ITCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/itcf_pkg.sv -----
// Shared types, constants and helper functions of the tilt filter.
// No dependencies.
package itcf_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(CORDIC_STEPS - 1);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CPD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND  = 3'd5;

	localparam logic [19:0] CPD_SCALE = 20'd1000000;
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;

	localparam int XY_W = 36;
	localparam int Z_W = 27;
	localparam logic signed [Z_W-1:0] ANG_90 = Z_W'(90 * 65536);

	typedef struct packed {
		logic signed [15:0] bias_x;
		logic signed [15:0] bias_y;
		logic signed [15:0] bias_z;
		logic [11:0]        cpd;
		logic [15:0]        period;
		logic [16:0]        weight;
	} itcf_cfg_t;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
	} itcf_sample_t;

	typedef struct packed {
		logic accept;
		logic prep;
		logic load;
		logic run;
		logic cordic_step;
		logic pitch_load;
		logic mul;
		logic commit;
	} itcf_cmd_t;

	// atan(2^-i) in Q16.16 degrees
	function automatic logic [22:0] atan_q16(input logic [4:0] i);
		logic [22:0] a;
		case (i)
			5'd0: a = 23'd2949120;
			5'd1: a = 23'd1740967;
			5'd2: a = 23'd919879;
			5'd3: a = 23'd466945;
			5'd4: a = 23'd234379;
			5'd5: a = 23'd117304;
			5'd6: a = 23'd58666;
			5'd7: a = 23'd29335;
			5'd8: a = 23'd14668;
			5'd9: a = 23'd7334;
			5'd10: a = 23'd3667;
			5'd11: a = 23'd1833;
			5'd12: a = 23'd917;
			5'd13: a = 23'd458;
			5'd14: a = 23'd229;
			5'd15: a = 23'd115;
			5'd16: a = 23'd57;
			5'd17: a = 23'd29;
			5'd18: a = 23'd14;
			5'd19: a = 23'd7;
			5'd20: a = 23'd4;
			5'd21: a = 23'd2;
			5'd22: a = 23'd1;
			default: a = 23'd0;
		endcase
		return a;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647) r = 32'h7FFFFFFF;
		else if (v < -40'sd2147483648) r = 32'h80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

// ----- rtl/itcf_if.sv -----
// Channel interfaces of the tilt filter: sample in, angles out, register writes.
// No dependencies.
interface itcf_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] rate_x;
	logic signed [15:0] rate_y;
	logic signed [15:0] rate_z;
	modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
		input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
		output ready);
endinterface

interface itcf_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] roll_deg;
	logic signed [31:0] pitch_deg;
	logic signed [31:0] yaw_deg;
	modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
	modport sink (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

interface itcf_cfg_if;
	logic valid;
	logic ready;
	logic [2:0]  index;
	logic [16:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/itcf_ctrl.sv -----
// Sequencer of the tilt filter: steps the datapath through one sample.
// Depends on itcf_pkg and the assertion macro header.
`include "imu_tilt_complementary_filter_macros.svh"

module itcf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output itcf_pkg::itcf_cmd_t cmd,
	output logic [itcf_pkg::CNT_W-1:0] step
);
	import itcf_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_PREP     = 3'd1;
	localparam logic [2:0] S_LOAD     = 3'd2;
	localparam logic [2:0] S_RUN      = 3'd3;
	localparam logic [2:0] S_PITCH_LD = 3'd4;
	localparam logic [2:0] S_PITCH    = 3'd5;
	localparam logic [2:0] S_MUL      = 3'd6;
	localparam logic [2:0] S_DONE     = 3'd7;

	logic [2:0] state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic slot_free;
	logic cnt_last;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign step = cnt_q;
	assign slot_free = !out_valid_q || out_ready;
	assign cnt_last = (state_q == S_RUN) ? (cnt_q == {CNT_W{1'b1}}) : (cnt_q == STEP_LAST);

	always_comb begin
		cmd = '0;
		cmd.accept = in_valid && in_ready;
		cmd.prep = (state_q == S_PREP);
		cmd.load = (state_q == S_LOAD);
		cmd.run = (state_q == S_RUN);
		cmd.cordic_step = ((state_q == S_RUN) &&
			({1'b0, cnt_q} < (CNT_W+1)'(CORDIC_STEPS))) || (state_q == S_PITCH);
		cmd.pitch_load = (state_q == S_PITCH_LD);
		cmd.mul = (state_q == S_MUL);
		cmd.commit = (state_q == S_DONE) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_PREP;
			S_PREP: state_d = S_LOAD;
			S_LOAD: state_d = S_RUN;
			S_RUN: if (cnt_last) state_d = S_PITCH_LD;
			S_PITCH_LD: state_d = S_PITCH;
			S_PITCH: if (cnt_last) state_d = S_MUL;
			S_MUL: state_d = S_DONE;
			S_DONE: if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_RUN || state_q == S_PITCH) && !cnt_last)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	`ITCF_ASSERT_NEXT(a_accept_preps, cmd.accept, state_q == S_PREP, "accept did not start prep")
	`ITCF_ASSERT_NOW(a_commit_free, cmd.commit, !out_valid_q || out_ready, "commit over unread result")
	`ITCF_ASSERT_NEXT(a_run_from_zero, state_q == S_LOAD, cnt_q == '0, "run began with nonzero count")
	`ITCF_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid_q, "committed result not shown")

endmodule

// ----- rtl/itcf_dpath.sv -----
// Datapath of the tilt filter: gyro scaling dividers, square root, shared CORDIC,
// blend multipliers and the angle estimates. Depends on itcf_pkg.
module itcf_dpath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  itcf_pkg::itcf_cmd_t      cmd,
	input  logic [itcf_pkg::CNT_W-1:0] step,
	input  itcf_pkg::itcf_cfg_t      cfg,
	input  itcf_pkg::itcf_sample_t   sample,
	output logic signed [31:0]      roll_deg,
	output logic signed [31:0]      pitch_deg,
	output logic signed [31:0]      yaw_deg
);
	import itcf_pkg::*;

	// latched sample
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [15:0] g_q [3];

	// prep products
	logic [30:0] mp_q [3];
	logic        neg_q [3];
	logic [31:0] den_q;
	logic [31:0] sq_q;

	// dividers, one lane per axis
	logic [31:0] drem_q [3];
	logic [31:0] dlo_q [3];

	// square root
	logic [31:0] ssh_q;
	logic [33:0] srem_q;
	logic [31:0] root_q;

	// CORDIC
	logic signed [XY_W-1:0] cx_q, cy_q;
	logic signed [Z_W-1:0]  cz_q;
	logic                   cnull_q;
	logic signed [Z_W-1:0]  acc_roll_q;

	// blend products
	logic signed [51:0] pe_roll_q, pe_pitch_q;
	logic signed [44:0] pa_roll_q, pa_pitch_q;
	logic signed [33:0] yaw_sum_q;

	logic signed [31:0] roll_q, pitch_q, yaw_q;

	logic [11:0] cpd_eff;
	logic [16:0] wgt;
	logic [16:0] wgt_inv;
	logic signed [XY_W-1:0] ld_x, ld_y;
	logic signed [Z_W-1:0]  cz_res;
	logic signed [32:0] dlt [3];

	assign cpd_eff = (cfg.cpd == 12'd0) ? 12'd1 : cfg.cpd;
	assign wgt = (cfg.weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.weight;
	assign wgt_inv = WEIGHT_ONE - wgt;
	assign cz_res = cnull_q ? '0 : cz_q;

	always_comb begin
		for (int i = 0; i < 3; i++)
			dlt[i] = neg_q[i] ? -$signed({1'b0, dlo_q[i]}) : $signed({1'b0, dlo_q[i]});
	end

	// CORDIC source: roll uses (az, ay), pitch uses (r, -ax)
	always_comb begin
		if (cmd.pitch_load) begin
			ld_x = $signed({{(XY_W-32){1'b0}}, root_q});
			ld_y = -($signed(XY_W'(ax_q)) <<< 16);
		end else begin
			ld_x = $signed(XY_W'(az_q)) <<< 16;
			ld_y = $signed(XY_W'(ay_q)) <<< 16;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ax_q <= sample.accel_x;
			ay_q <= sample.accel_y;
			az_q <= sample.accel_z;
			g_q[0] <= sample.rate_x + cfg.bias_x;
			g_q[1] <= sample.rate_y + cfg.bias_y;
			g_q[2] <= sample.rate_z + cfg.bias_z;
		end

		if (cmd.prep) begin
			for (int i = 0; i < 3; i++) begin
				logic [16:0] mag;
				mag = g_q[i][15] ? 17'(-$signed({g_q[i][15], g_q[i]})) : {1'b0, g_q[i]};
				neg_q[i] <= g_q[i][15];
				mp_q[i] <= 31'(mag * cfg.period);
			end
			den_q <= 32'(cpd_eff * CPD_SCALE);
			sq_q <= 32'(ay_q * ay_q) + 32'(az_q * az_q);
		end

		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				logic [34:0] m10;
				logic [51:0] n;
				m10 = {mp_q[i], 3'b0} + {2'b0, mp_q[i], 1'b0};
				n = {1'b0, m10, 16'b0} + {21'b0, den_q[31:1]};
				drem_q[i] <= {12'b0, n[51:32]};
				dlo_q[i] <= n[31:0];
			end
			ssh_q <= sq_q;
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.run) begin
			for (int i = 0; i < 3; i++) begin
				logic [32:0] tr;
				logic qb;
				tr = {drem_q[i], dlo_q[i][31]};
				qb = (tr >= {1'b0, den_q});
				drem_q[i] <= qb ? 32'(tr - {1'b0, den_q}) : tr[31:0];
				dlo_q[i] <= {dlo_q[i][30:0], qb};
			end
			begin
				logic [35:0] st;
				logic [35:0] sd;
				st = {srem_q, ssh_q[31:30]};
				sd = {2'b0, root_q, 2'b01};
				ssh_q <= {ssh_q[29:0], 2'b00};
				if (st >= sd) begin
					srem_q <= 34'(st - sd);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					srem_q <= st[33:0];
					root_q <= {root_q[30:0], 1'b0};
				end
			end
		end

		if (cmd.load || cmd.pitch_load) begin
			cnull_q <= (ld_x == '0) && (ld_y == '0);
			if (ld_x < 0) begin
				if (ld_y >= 0) begin
					cx_q <= ld_y;
					cy_q <= -ld_x;
					cz_q <= ANG_90;
				end else begin
					cx_q <= -ld_y;
					cy_q <= ld_x;
					cz_q <= -ANG_90;
				end
			end else begin
				cx_q <= ld_x;
				cy_q <= ld_y;
				cz_q <= '0;
			end
		end else if (cmd.cordic_step) begin
			logic signed [XY_W-1:0] xs, ys;
			logic signed [Z_W-1:0] an;
			xs = cx_q >>> step;
			ys = cy_q >>> step;
			an = $signed(Z_W'(atan_q16(step)));
			if (cy_q >= 0) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + an;
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - an;
			end
		end

		if (cmd.pitch_load)
			acc_roll_q <= cz_res;

		if (cmd.mul) begin
			pe_roll_q <= $signed({1'b0, wgt}) * (34'(roll_q) + 34'(dlt[0]));
			pe_pitch_q <= $signed({1'b0, wgt}) * (34'(pitch_q) + 34'(dlt[1]));
			pa_roll_q <= $signed({1'b0, wgt_inv}) * acc_roll_q;
			pa_pitch_q <= $signed({1'b0, wgt_inv}) * cz_res;
			yaw_sum_q <= 34'(yaw_q) + 34'(dlt[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q <= '0;
			pitch_q <= '0;
			yaw_q <= '0;
		end else if (cmd.commit) begin
			logic signed [52:0] vr, vp;
			vr = 53'(pe_roll_q) + 53'(pa_roll_q) + 53'sd32768;
			vp = 53'(pe_pitch_q) + 53'(pa_pitch_q) + 53'sd32768;
			roll_q <= sat32(40'(vr >>> 16));
			pitch_q <= sat32(40'(vp >>> 16));
			yaw_q <= sat32(40'(yaw_sum_q));
		end
	end

	assign roll_deg = roll_q;
	assign pitch_deg = pitch_q;
	assign yaw_deg = yaw_q;

endmodule

// ----- rtl/imu_tilt_complementary_filter.sv -----
// One sample is processed at a time: in_ready returns only after the previous result is
// committed, past the 32-step bit-serial gyro dividers and square root, 16 CORDIC steps
// for pitch, and any stall on the angle side.
// Reset (arst_n low) clears the angle estimates to zero and loads register defaults.
// Register writes are taken in any cycle; ready is always high on that port.
module imu_tilt_complementary_filter (
	input logic       clk,
	input logic       arst_n,
	itcf_in_if.sink   in_ch,
	itcf_out_if.source out_ch,
	itcf_cfg_if.sink  cfg
);
	import itcf_pkg::*;

	itcf_cfg_t    cfg_q;
	itcf_cmd_t    cmd;
	itcf_sample_t sample;
	logic [CNT_W-1:0] step;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bias_x <= '0;
			cfg_q.bias_y <= '0;
			cfg_q.bias_z <= '0;
			cfg_q.cpd <= 12'd164;
			cfg_q.period <= 16'd2000;
			cfg_q.weight <= 17'd64225;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BIAS_X: cfg_q.bias_x <= cfg.data[15:0];
				REG_BIAS_Y: cfg_q.bias_y <= cfg.data[15:0];
				REG_BIAS_Z: cfg_q.bias_z <= cfg.data[15:0];
				REG_CPD: cfg_q.cpd <= cfg.data[11:0];
				REG_PERIOD: cfg_q.period <= cfg.data[15:0];
				REG_BLEND: cfg_q.weight <= cfg.data;
				default: ;
			endcase
		end
	end

	assign sample.accel_x = in_ch.accel_x;
	assign sample.accel_y = in_ch.accel_y;
	assign sample.accel_z = in_ch.accel_z;
	assign sample.rate_x = in_ch.rate_x;
	assign sample.rate_y = in_ch.rate_y;
	assign sample.rate_z = in_ch.rate_z;

	itcf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.cmd(cmd),
		.step(step)
	);

	itcf_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.step(step),
		.cfg(cfg_q),
		.sample(sample),
		.roll_deg(out_ch.roll_deg),
		.pitch_deg(out_ch.pitch_deg),
		.yaw_deg(out_ch.yaw_deg)
	);

endmodule

// ----- verif/imu_tilt_complementary_filter_checker.sv -----
// Checker for the tilt filter: watches the sample, angle and register channels,
// predicts each angle set and compares it. Depends on itcf_pkg and itcf_if.sv.
module imu_tilt_complementary_filter_checker (
	input logic      clk,
	input logic      arst_n,
	itcf_in_if       in_ch,
	itcf_out_if      out_ch,
	itcf_cfg_if      cfg,
	output int       errors,
	output int       pending
);
	import itcf_pkg::*;

	typedef struct {
		logic signed [31:0] roll;
		logic signed [31:0] pitch;
		logic signed [31:0] yaw;
	} angles_t;

	angles_t angle_queue[$];
	itcf_cfg_t regs;
	longint roll_est, pitch_est, yaw_est;

	function automatic longint shr_floor(longint v, int s);
		return v >= 0 ? (v >>> s) : ~((~v) >>> s);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint root_floor(longint unsigned s);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	// own table of atan(2^-i) in Q16.16 degrees
	function automatic int atan_tbl(int i);
		int t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
			14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
		return i < 23 ? t[i] : 0;
	endfunction

	function automatic longint tilt_angle(longint y, longint x);
		longint z, t, a, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 90 * 65536;
			end else begin
				x = -y; y = t; z = -(90 * 65536);
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			a = longint'(atan_tbl(i));
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += a;
			end else begin
				x -= ys; y += xs; z -= a;
			end
		end
		return z;
	endfunction

	function automatic longint rate_step(logic signed [15:0] rate, logic signed [15:0] bias);
		logic signed [15:0] g;
		longint unsigned mag, cpd, den, num, q;
		g = rate + bias;
		mag = g < 0 ? longint'(-longint'(g)) : longint'(g);
		cpd = regs.cpd == 0 ? 1 : regs.cpd;
		den = cpd * 1000000;
		num = mag * 10 * regs.period * 65536;
		q = (num + den / 2) / den;
		return g < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint mix(longint est, longint d, longint acc);
		longint a, v;
		a = regs.weight > WEIGHT_ONE ? 65536 : longint'(regs.weight);
		v = a * (est + d) + (65536 - a) * acc;
		return clamp32(shr_floor(v + 32768, 16));
	endfunction

	task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	assign pending = angle_queue.size();

	always @(posedge clk or negedge arst_n) begin
		longint ax, ay, az, dx, dy, dz, r, acc_r, acc_p;
		angles_t e;
		if (!arst_n) begin
			regs <= '{bias_x: 0, bias_y: 0, bias_z: 0, cpd: 164, period: 2000, weight: 64225};
			roll_est = 0; pitch_est = 0; yaw_est = 0;
			errors = 0;
			angle_queue.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_BIAS_X: regs.bias_x <= cfg.data[15:0];
					REG_BIAS_Y: regs.bias_y <= cfg.data[15:0];
					REG_BIAS_Z: regs.bias_z <= cfg.data[15:0];
					REG_CPD:    regs.cpd <= cfg.data[11:0];
					REG_PERIOD: regs.period <= cfg.data[15:0];
					REG_BLEND:  regs.weight <= cfg.data;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				ax = in_ch.accel_x; ay = in_ch.accel_y; az = in_ch.accel_z;
				dx = rate_step(in_ch.rate_x, regs.bias_x);
				dy = rate_step(in_ch.rate_y, regs.bias_y);
				dz = rate_step(in_ch.rate_z, regs.bias_z);
				r = root_floor(longint'(ay * ay + az * az) << 32);
				acc_r = tilt_angle(ay * 65536, az * 65536);
				acc_p = tilt_angle(-ax * 65536, r);
				roll_est = mix(roll_est, dx, acc_r);
				pitch_est = mix(pitch_est, dy, acc_p);
				yaw_est = clamp32(yaw_est + dz);
				e.roll = roll_est[31:0];
				e.pitch = pitch_est[31:0];
				e.yaw = yaw_est[31:0];
				angle_queue.push_back(e);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (angle_queue.size() == 0) begin
					$display("unexpected angle transaction at %0t", $time);
					errors++;
				end else begin
					e = angle_queue.pop_front();
					if (out_ch.roll_deg !== e.roll) report("roll", out_ch.roll_deg, e.roll);
					if (out_ch.pitch_deg !== e.pitch) report("pitch", out_ch.pitch_deg, e.pitch);
					if (out_ch.yaw_deg !== e.yaw) report("yaw", out_ch.yaw_deg, e.yaw);
				end
			end
		end
	end
endmodule

// ----- verif/imu_tilt_complementary_filter_test.sv -----
// Testbench top for the tilt filter: drives samples and register writes,
// stalls the angle side, and prints the verdict. Depends on the checker and itcf_if.sv.
module imu_tilt_complementary_filter_test;
	import itcf_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int errors, pending;
	logic hold_off = 0;
	logic stall_done = 0;

	itcf_in_if  in_ch();
	itcf_out_if out_ch();
	itcf_cfg_if cfg();

	imu_tilt_complementary_filter uut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch), .cfg(cfg));
	imu_tilt_complementary_filter_checker chk (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch), .cfg(cfg), .errors(errors), .pending(pending));

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		in_ch.valid = 0; in_ch.accel_x = 0; in_ch.accel_y = 0; in_ch.accel_z = 0;
		in_ch.rate_x = 0; in_ch.rate_y = 0; in_ch.rate_z = 0;
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
		out_ch.ready = 0;
	end

	// receiver: random stalls, one long hold-off
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (hold_off && !stall_done) begin
				out_ch.ready <= 0;
				repeat (600) @(posedge clk);
				stall_done <= 1;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			if (w != 0) begin
				out_ch.ready <= 0;
				repeat (w) @(posedge clk);
			end
			out_ch.ready <= 1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] val);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic send_sample(logic [15:0] ax, ay, az, gx, gy, gz, bit no_gap);
		int w;
		w = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
		if (w != 0) begin
			in_ch.valid <= 0;
			repeat (w) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.accel_x <= ax; in_ch.accel_y <= ay; in_ch.accel_z <= az;
		in_ch.rate_x <= gx; in_ch.rate_y <= gy; in_ch.rate_z <= gz;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic rand_sample(bit no_gap);
		logic [15:0] v[6];
		for (int k = 0; k < 6; k++) begin
			case ($urandom_range(0, 5))
				0: v[k] = 16'h8000;
				1: v[k] = 16'h7FFF;
				2: v[k] = 16'(int'($urandom_range(0, 64)) - 32);
				3: v[k] = 16'(int'($urandom_range(0, 4000)) - 2000);
				default: v[k] = $urandom;
			endcase
		end
		send_sample(v[0], v[1], v[2], v[3], v[4], v[5], no_gap);
	endtask

	task automatic rand_regs(int mode);
		write_reg(REG_BIAS_X, 17'($urandom));
		write_reg(REG_BIAS_Y, 17'($urandom_range(0, 1) ? 16'h8000 : 16'($urandom_range(0, 200))));
		write_reg(REG_BIAS_Z, 17'($urandom));
		case (mode)
			0: begin
				write_reg(REG_CPD, 17'd1); write_reg(REG_PERIOD, 17'd65535);
				write_reg(REG_BLEND, 17'd65536);
			end
			1: begin
				write_reg(REG_CPD, 17'd2620); write_reg(REG_PERIOD, 17'd1);
				write_reg(REG_BLEND, 17'd0);
			end
			2: begin
				// zero sensitivity, zero period, weight above one
				write_reg(REG_CPD, 17'd0); write_reg(REG_PERIOD, 17'd0);
				write_reg(REG_BLEND, 17'h1FFFF);
			end
			3: write_reg(3'd7, 17'($urandom));
			default: begin
				write_reg(REG_CPD, 17'($urandom_range(0, 4095)));
				write_reg(REG_PERIOD, 17'($urandom));
				write_reg(REG_BLEND, 17'($urandom_range(0, 131071)));
			end
		endcase
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes and null vectors at reset settings
		send_sample(0, 0, 0, 0, 0, 0, 0);
		send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
		send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
		send_sample(16'h7FFF, 0, 0, 0, 0, 0, 0);
		send_sample(16'h8000, 0, 16'hFFFF, 1, 16'hFFFF, 0, 0);
		send_sample(0, 16'h8000, 16'h7FFF, 0, 0, 16'h7FFF, 0);
		send_sample(0, 16'h7FFF, 16'h8000, 0, 0, 16'h7FFF, 0);
		send_sample(0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0);
		send_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 0);
		in_ch.valid <= 0;
		drain();
		for (int m = 0; m < 3; m++) begin
			rand_regs(m);
			repeat (5) rand_sample(0);
			in_ch.valid <= 0;
			drain();
		end
		// yaw saturation: fast integration both ways
		write_reg(REG_CPD, 17'd1); write_reg(REG_PERIOD, 17'd65535);
		write_reg(REG_BIAS_Z, 17'd0);
		repeat (4) send_sample(0, 0, 100, 0, 0, 16'h7FFF, 1);
		repeat (8) send_sample(0, 0, 100, 0, 0, 16'h8000, 1);
		in_ch.valid <= 0;
		drain();
		// long receiver stall with the sender still pushing
		hold_off <= 1;
		for (int k = 0; k < 12; k++) rand_sample(1);
		while (!stall_done) @(posedge clk);
		hold_off <= 0;
		for (int p = 0; p < 30; p++) begin
			in_ch.valid <= 0;
			drain();
			rand_regs(p % 6);
			repeat (50) rand_sample($urandom_range(0, 4) == 0);
		end
		in_ch.valid <= 0;
		drain();
		if (errors == 0) $display("** imu_tilt_complementary_filter: PASSED **");
		else $display("** imu_tilt_complementary_filter: FAILED **");
		$finish;
	end

	initial begin
		#20000000;
		$display("** imu_tilt_complementary_filter: FAILED **");
		$finish;
	end
endmodule
